// File: sv/rendezvous_send_queue_core_defines.svh
// Assertion macros for the rendezvous send queue core.
// Included by the top level; no other dependencies.
`ifndef RENDEZVOUS_SEND_QUEUE_CORE_DEFINES_SVH
`define RENDEZVOUS_SEND_QUEUE_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define RSQ_ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("rsq: same-cycle implication violated");
`define RSQ_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("rsq: next-cycle implication violated");
`else
`define RSQ_ASSERT_IMPL(label, clk, rst_n, pre, post)
`define RSQ_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// File: sv/rsq_pkg.sv
// Shared types, codes and constants of the rendezvous send queue core.
// Has no dependencies; used by every module of the block.
package rsq_pkg;

  localparam int unsigned DEFAULT_QUEUE_DEPTH = 16;
  localparam int unsigned PEND_W = 5;
  localparam int unsigned CFG_INDEX_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [2:0] MODE_INSERT     = 3'd0;
  localparam logic [2:0] MODE_OPEN_OK    = 3'd1;
  localparam logic [2:0] MODE_REFUSED    = 3'd2;
  localparam logic [2:0] MODE_WRITE_DONE = 3'd3;
  localparam logic [2:0] MODE_CLOSE_DONE = 3'd4;
  localparam logic [2:0] MODE_FAIL_DONE  = 3'd5;

  localparam logic [2:0] ACT_OPEN  = 3'd0;
  localparam logic [2:0] ACT_FAIL  = 3'd1;
  localparam logic [2:0] ACT_WRITE = 3'd2;
  localparam logic [2:0] ACT_CLOSE = 3'd3;
  localparam logic [2:0] ACT_DONE  = 3'd4;
  localparam logic [2:0] ACT_EMPTY = 3'd5;
  localparam logic [2:0] ACT_PHASE = 3'd6;
  localparam logic [2:0] ACT_FULL  = 3'd7;

  localparam logic [CFG_INDEX_W-1:0] CFG_PEER_RANK    = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_TRANSFER_TAG = CFG_INDEX_W'(1);

  typedef enum logic [2:0] {
    PH_WAIT  = 3'd0,
    PH_OPEN  = 3'd1,
    PH_WRITE = 3'd2,
    PH_CLOSE = 3'd3,
    PH_FAIL  = 3'd4
  } phase_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] item_id;
    logic [31:0] item_bytes;
    logic [63:0] dst_addr;
    logic [31:0] dst_key;
    logic        region_ok;
    logic [63:0] src_addr;
    logic [31:0] src_key;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        action;
    logic [15:0]       item_id;
    logic [31:0]       bytes;
    logic [63:0]       dst_addr;
    logic [31:0]       dst_key;
    logic [63:0]       src_addr;
    logic [31:0]       src_key;
    logic              done_ok;
    logic [PEND_W-1:0] pending_count;
    logic              last;
  } result_t;

  typedef struct packed {
    logic [15:0] item_id;
    logic [31:0] bytes;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load_next;
  } ctrl_cmd_t;

  typedef struct packed {
    logic emit;
    logic more;
    logic out_free;
  } ctrl_status_t;

endpackage

// File: sv/rsq_controller.sv
// Sequencing state machine of the rendezvous send queue core.
// Depends on rsq_pkg for the command and status structs.
module rsq_controller import rsq_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  ctrl_status_t status_i,
  output ctrl_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_READ = 4'b0100,
    ST_NEXT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!status_i.emit || status_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d = status_i.more ? ST_READ : ST_IDLE;
        end
      end
      ST_READ: begin
        state_d = ST_NEXT;
      end
      ST_NEXT: begin
        if (status_i.out_free) begin
          cmd_o.load_next = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: sv/rsq_datapath.sv
// Datapath of the rendezvous send queue core: queue memory, pointers,
// head phase, configuration registers and the result register. Uses rsq_pkg.
module rsq_datapath import rsq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_write_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  in_item_t               item_i,
  input  ctrl_cmd_t              cmd_i,
  output ctrl_status_t           status_o,
  input  logic                   out_stall_i,
  output logic                   out_valid_o,
  output result_t                result_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [15:0] peer_rank_q;
  logic [31:0] transfer_tag_q;

  in_item_t          in_q;
  entry_t            queue_mem_q [QUEUE_DEPTH];
  entry_t            head_q;
  logic [PTR_W-1:0]  rd_ptr_q, wr_ptr_q;
  logic [CNT_W-1:0]  count_q;
  phase_e            phase_q;
  result_t           out_q;
  logic              out_valid_q;

  result_t          exec_res, next_res;
  logic             emit, more, do_write, do_pop;
  logic [CNT_W-1:0] count_next;
  phase_e           phase_next, need_phase;
  logic             full, empty;

  assign full  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty = (count_q == '0);

  always_comb begin
    case (in_q.mode)
      MODE_OPEN_OK, MODE_REFUSED: need_phase = PH_OPEN;
      MODE_WRITE_DONE:            need_phase = PH_WRITE;
      MODE_CLOSE_DONE:            need_phase = PH_CLOSE;
      default:                    need_phase = PH_FAIL;
    endcase
  end

  always_comb begin
    exec_res = '0;
    emit = 1'b0;
    more = 1'b0;
    do_write = 1'b0;
    do_pop = 1'b0;
    count_next = count_q;
    phase_next = phase_q;
    if (in_q.mode == MODE_INSERT) begin
      if (full) begin
        exec_res.action = ACT_FULL;
        emit = 1'b1;
      end else begin
        do_write = 1'b1;
        count_next = count_q + CNT_W'(1);
        if (empty && phase_q == PH_WAIT) begin
          exec_res.action = ACT_OPEN;
          exec_res.item_id = in_q.item_id;
          exec_res.bytes = in_q.item_bytes;
          phase_next = PH_OPEN;
          emit = 1'b1;
        end
      end
    end else if (in_q.mode > MODE_FAIL_DONE) begin
      exec_res.action = ACT_PHASE;
      emit = 1'b1;
    end else if (in_q.mode != MODE_WRITE_DONE && empty) begin
      exec_res.action = ACT_EMPTY;
      emit = 1'b1;
    end else if (phase_q != need_phase || empty) begin
      exec_res.action = ACT_PHASE;
      emit = 1'b1;
    end else if (in_q.mode == MODE_OPEN_OK) begin
      emit = 1'b1;
      exec_res.item_id = head_q.item_id;
      if (!in_q.region_ok) begin
        exec_res.action = ACT_FAIL;
        phase_next = PH_FAIL;
      end else begin
        exec_res.action = ACT_WRITE;
        exec_res.bytes = head_q.bytes;
        exec_res.dst_addr = in_q.dst_addr;
        exec_res.dst_key = in_q.dst_key;
        exec_res.src_addr = in_q.src_addr;
        exec_res.src_key = in_q.src_key;
        phase_next = PH_WRITE;
      end
    end else if (in_q.mode == MODE_WRITE_DONE) begin
      emit = 1'b1;
      exec_res.action = ACT_CLOSE;
      exec_res.item_id = head_q.item_id;
      phase_next = PH_CLOSE;
    end else begin
      emit = 1'b1;
      do_pop = 1'b1;
      exec_res.action = ACT_DONE;
      exec_res.item_id = head_q.item_id;
      exec_res.done_ok = (in_q.mode == MODE_CLOSE_DONE);
      count_next = count_q - CNT_W'(1);
      phase_next = PH_WAIT;
      more = (count_q != CNT_W'(1));
    end
    exec_res.pending_count = PEND_W'(count_next);
    exec_res.last = !more;
  end

  always_comb begin
    next_res = '0;
    next_res.action = ACT_OPEN;
    next_res.item_id = head_q.item_id;
    next_res.bytes = head_q.bytes;
    next_res.pending_count = PEND_W'(count_q);
    next_res.last = 1'b1;
  end

  assign status_o.emit = emit;
  assign status_o.more = more;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peer_rank_q <= '0;
      transfer_tag_q <= '0;
    end else if (cfg_write_i) begin
      if (cfg_index_i == CFG_PEER_RANK) begin
        peer_rank_q <= cfg_data_i[15:0];
      end else if (cfg_index_i == CFG_TRANSFER_TAG) begin
        transfer_tag_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q <= item_i;
    end
    if (cmd_i.exec && do_write) begin
      queue_mem_q[wr_ptr_q] <= '{item_id: in_q.item_id, bytes: in_q.item_bytes};
    end
    head_q <= queue_mem_q[rd_ptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q <= '0;
      phase_q <= PH_WAIT;
    end else if (cmd_i.exec) begin
      count_q <= count_next;
      phase_q <= phase_next;
      if (do_write) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
    end else if (cmd_i.load_next) begin
      phase_q <= PH_OPEN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((cmd_i.exec && emit) || cmd_i.load_next) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && emit) begin
      out_q <= exec_res;
    end else if (cmd_i.load_next) begin
      out_q <= next_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o = out_q;

endmodule

// File: sv/rendezvous_send_queue_core.sv
// The idle state accepts an event, capturing the transaction and reading the head entry of
// the queue memory; the exec state decides, posts the first result and updates the queue.
// A retirement that leaves items queued also passes the read and next states, as the open
// for the new head waits for the registered read at the advanced read pointer. Results sit in
// an output register, so the next event is accepted while the final result of the previous
// one still waits; an event that posts a result then holds in its decision cycle until that
// register is taken. The queue memory needs no clearing after reset.
// Top level; uses rsq_pkg, rsq_controller, rsq_datapath and the assertion macros.
`include "rendezvous_send_queue_core_defines.svh"

module rendezvous_send_queue_core import rsq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [2:0]             mode_i,
  input  logic [15:0]            item_id_i,
  input  logic [31:0]            item_bytes_i,
  input  logic [63:0]            dst_addr_i,
  input  logic [31:0]            dst_key_i,
  input  logic                   region_ok_i,
  input  logic [63:0]            src_addr_i,
  input  logic [31:0]            src_key_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [2:0]             action_o,
  output logic [15:0]            out_item_id_o,
  output logic [31:0]            out_bytes_o,
  output logic [63:0]            write_dst_addr_o,
  output logic [31:0]            write_dst_key_o,
  output logic [63:0]            write_src_addr_o,
  output logic [31:0]            write_src_key_o,
  output logic                   done_ok_o,
  output logic [PEND_W-1:0]      pending_count_o,
  output logic                   last_o
);

  in_item_t     item;
  result_t      result;
  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  assign cfg_ready_o = 1'b1;

  assign item.mode = mode_i;
  assign item.item_id = item_id_i;
  assign item.item_bytes = item_bytes_i;
  assign item.dst_addr = dst_addr_i;
  assign item.dst_key = dst_key_i;
  assign item.region_ok = region_ok_i;
  assign item.src_addr = src_addr_i;
  assign item.src_key = src_key_i;

  rsq_controller u_controller (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rsq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_write_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (item),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .result_o    (result)
  );

  assign action_o = result.action;
  assign out_item_id_o = result.item_id;
  assign out_bytes_o = result.bytes;
  assign write_dst_addr_o = result.dst_addr;
  assign write_dst_key_o = result.dst_key;
  assign write_src_addr_o = result.src_addr;
  assign write_src_key_o = result.src_key;
  assign done_ok_o = result.done_ok;
  assign pending_count_o = result.pending_count;
  assign last_o = result.last;

  `RSQ_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `RSQ_ASSERT_IMPL(a_only_done_not_last, clk_i, rst_ni, out_valid_o && !last_o, action_o == ACT_DONE)
  `RSQ_ASSERT_IMPL(a_no_accept_mid_retire, clk_i, rst_ni, out_valid_o && !last_o, in_stall_o)

endmodule

// File: test/rsq_message_checker.sv
// Checker for the rendezvous send queue core: predicts the posted messages of each accepted
// event and compares every result transaction with the oldest outstanding prediction.
// Depends on rsq_pkg; instantiated beside the block by tb_rendezvous_send_queue_core.
module rsq_message_checker import rsq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  in_item_t               event_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  result_t                msg_i,
  output int                     failures_o,
  output int                     due_o
);

  localparam int REPORT_LIMIT = 10;

  logic [15:0] peer_rank;
  logic [31:0] transfer_tag;
  phase_e      head_phase;
  logic [15:0] id_mem [QUEUE_DEPTH];
  logic [31:0] size_mem [QUEUE_DEPTH];
  int unsigned rd_ptr;
  int unsigned wr_ptr;
  int unsigned queued;
  result_t     due_msgs [$];
  result_t     step_msgs [$];
  int          failures;

  function automatic result_t blank_msg(logic [2:0] action);
    result_t m;
    m = '0;
    m.action = action;
    return m;
  endfunction

  function automatic string describe(result_t r);
    return {$sformatf("action %0d id %h bytes %h daddr %h dkey %h",
                      r.action, r.item_id, r.bytes, r.dst_addr, r.dst_key),
            $sformatf(" saddr %h skey %h ok %b pend %0d last %b",
                      r.src_addr, r.src_key, r.done_ok, r.pending_count, r.last)};
  endfunction

  task automatic post_open();
    result_t m;
    m = blank_msg(ACT_OPEN);
    m.item_id = id_mem[rd_ptr];
    m.bytes = size_mem[rd_ptr];
    head_phase = PH_OPEN;
    step_msgs.push_back(m);
  endtask

  task automatic plan_messages(in_item_t ev);
    result_t m;
    phase_e  need;
    step_msgs.delete();
    if (ev.mode == MODE_INSERT) begin
      if (queued >= QUEUE_DEPTH) begin
        step_msgs.push_back(blank_msg(ACT_FULL));
      end else begin
        id_mem[wr_ptr] = ev.item_id;
        size_mem[wr_ptr] = ev.item_bytes;
        wr_ptr = (wr_ptr + 1) % QUEUE_DEPTH;
        queued++;
        if (queued == 1 && head_phase == PH_WAIT) post_open();
      end
    end else if (ev.mode > MODE_FAIL_DONE) begin
      step_msgs.push_back(blank_msg(ACT_PHASE));
    end else begin
      case (ev.mode)
        MODE_OPEN_OK, MODE_REFUSED: need = PH_OPEN;
        MODE_WRITE_DONE: need = PH_WRITE;
        MODE_CLOSE_DONE: need = PH_CLOSE;
        default: need = PH_FAIL;
      endcase
      if (ev.mode != MODE_WRITE_DONE && queued == 0) begin
        step_msgs.push_back(blank_msg(ACT_EMPTY));
      end else if (head_phase != need || queued == 0) begin
        step_msgs.push_back(blank_msg(ACT_PHASE));
      end else if (ev.mode == MODE_OPEN_OK && !ev.region_ok) begin
        m = blank_msg(ACT_FAIL);
        m.item_id = id_mem[rd_ptr];
        head_phase = PH_FAIL;
        step_msgs.push_back(m);
      end else if (ev.mode == MODE_OPEN_OK) begin
        m = blank_msg(ACT_WRITE);
        m.item_id = id_mem[rd_ptr];
        m.bytes = size_mem[rd_ptr];
        m.dst_addr = ev.dst_addr;
        m.dst_key = ev.dst_key;
        m.src_addr = ev.src_addr;
        m.src_key = ev.src_key;
        head_phase = PH_WRITE;
        step_msgs.push_back(m);
      end else if (ev.mode == MODE_WRITE_DONE) begin
        m = blank_msg(ACT_CLOSE);
        m.item_id = id_mem[rd_ptr];
        head_phase = PH_CLOSE;
        step_msgs.push_back(m);
      end else begin
        // Close, failure or refusal retires the head; a next head, if any, is opened.
        m = blank_msg(ACT_DONE);
        m.item_id = id_mem[rd_ptr];
        m.done_ok = (ev.mode == MODE_CLOSE_DONE);
        step_msgs.push_back(m);
        rd_ptr = (rd_ptr + 1) % QUEUE_DEPTH;
        queued--;
        head_phase = PH_WAIT;
        if (queued != 0) post_open();
      end
    end
    foreach (step_msgs[k]) begin
      step_msgs[k].pending_count = PEND_W'(queued);
      step_msgs[k].last = (k == step_msgs.size() - 1);
      due_msgs.push_back(step_msgs[k]);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    result_t expected;
    if (!rst_ni) begin
      peer_rank = '0;
      transfer_tag = '0;
      head_phase = PH_WAIT;
      rd_ptr = 0;
      wr_ptr = 0;
      queued = 0;
      due_msgs.delete();
      failures = 0;
      failures_o <= 0;
      due_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (due_msgs.size() == 0) begin
          failures++;
          if (failures <= REPORT_LIMIT) begin
            $display("%0t: unexpected result: %s", $time, describe(msg_i));
          end
        end else begin
          expected = due_msgs.pop_front();
          if (msg_i !== expected) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
              $display("%0t: expected %s", $time, describe(expected));
              $display("%0t: actual   %s", $time, describe(msg_i));
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) plan_messages(event_i);
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_PEER_RANK: peer_rank = cfg_data_i[15:0];
          CFG_TRANSFER_TAG: transfer_tag = cfg_data_i;
          default: ;
        endcase
      end
      failures_o <= failures;
      due_o <= due_msgs.size();
    end
  end

endmodule

// File: test/tb_rendezvous_send_queue_core.sv
// Testbench top for the rendezvous send queue core: drives directed and random event
// sequences with random pacing on both channels, and reports the checker's verdict.
// Depends on rsq_pkg, rendezvous_send_queue_core and rsq_message_checker.
module tb_rendezvous_send_queue_core;
  import rsq_pkg::*;

  localparam int unsigned DEPTH = DEFAULT_QUEUE_DEPTH;
  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;
  localparam int GAP_MAX = 17;
  localparam int RANDOM_EVENTS = 1850;
  localparam int PHASES = 4;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  in_item_t               ev = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [2:0]             action;
  logic [15:0]            out_item_id;
  logic [31:0]            out_bytes;
  logic [63:0]            wr_raddr;
  logic [31:0]            wr_rkey;
  logic [63:0]            wr_laddr;
  logic [31:0]            wr_lkey;
  logic                   done_ok;
  logic [PEND_W-1:0]      pending_count;
  logic                   last_flag;
  int                     failures;
  int                     due;

  int     backlog = 0;
  phase_e head_step = PH_WAIT;
  int     burst = 0;
  int     sent_items = 0;
  bit     calm_in = 1'b0;
  int     stall_left = 0;
  int     results_seen = 0;
  bit     calm_out = 1'b0;

  always #6 clk = ~clk;

  rendezvous_send_queue_core #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .mode_i           (ev.mode),
    .item_id_i        (ev.item_id),
    .item_bytes_i     (ev.item_bytes),
    .dst_addr_i       (ev.dst_addr),
    .dst_key_i        (ev.dst_key),
    .region_ok_i      (ev.region_ok),
    .src_addr_i       (ev.src_addr),
    .src_key_i        (ev.src_key),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .action_o         (action),
    .out_item_id_o    (out_item_id),
    .out_bytes_o      (out_bytes),
    .write_dst_addr_o (wr_raddr),
    .write_dst_key_o  (wr_rkey),
    .write_src_addr_o (wr_laddr),
    .write_src_key_o  (wr_lkey),
    .done_ok_o        (done_ok),
    .pending_count_o  (pending_count),
    .last_o           (last_flag)
  );

  rsq_message_checker #(.QUEUE_DEPTH(DEPTH)) msg_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .event_i     (ev),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .msg_i       ({action, out_item_id, out_bytes, wr_raddr, wr_rkey, wr_laddr, wr_lkey,
                   done_ok, pending_count, last_flag}),
    .failures_o  (failures),
    .due_o       (due)
  );

  always @(posedge clk or negedge rst_n) begin : out_pacing
    int n;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (results_seen % 48 == 0) calm_out <= ($urandom_range(0, 2) == 0);
      n = calm_out ? 0 : $urandom_range(0, GAP_MAX);
      stall_left <= n;
      out_stall <= (n != 0);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= (stall_left > 1);
    end
  end

  function automatic in_item_t fresh_event(logic [2:0] mode, logic ok);
    in_item_t it;
    it.mode = mode;
    it.item_id = $urandom;
    it.item_bytes = $urandom;
    it.dst_addr = {$urandom, $urandom};
    it.dst_key = $urandom;
    it.region_ok = ok;
    it.src_addr = {$urandom, $urandom};
    it.src_key = $urandom;
    return it;
  endfunction

  function automatic bit is_illegal(logic [2:0] m);
    if (m == MODE_INSERT) return backlog >= DEPTH;
    if (backlog == 0 || m > MODE_FAIL_DONE) return 1'b1;
    case (head_step)
      PH_OPEN: return !(m == MODE_OPEN_OK || m == MODE_REFUSED);
      PH_WRITE: return m != MODE_WRITE_DONE;
      PH_CLOSE: return m != MODE_CLOSE_DONE;
      PH_FAIL: return m != MODE_FAIL_DONE;
      default: return 1'b1;
    endcase
  endfunction

  task automatic send(in_item_t it);
    int gap;
    sent_items++;
    if (sent_items % 40 == 0) calm_in = ($urandom_range(0, 2) == 0);
    gap = calm_in ? 0 : $urandom_range(0, GAP_MAX);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    ev <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_config(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure(logic [CFG_DATA_W-1:0] rank, logic [CFG_DATA_W-1:0] tag);
    write_config(CFG_PEER_RANK, rank);
    write_config(CFG_TRANSFER_TAG, tag);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic retire_head();
    backlog--;
    head_step = (backlog != 0) ? PH_OPEN : PH_WAIT;
  endtask

  task automatic run_directed();
    in_item_t it;
    send(fresh_event(MODE_CLOSE_DONE, 1'b1));
    send(fresh_event(MODE_WRITE_DONE, 1'b1));
    send(fresh_event(MODE_SPARE_LO, 1'b1));
    send(fresh_event(MODE_SPARE_HI, 1'b0));
    send(fresh_event(MODE_REFUSED, 1'b0));
    send(fresh_event(MODE_FAIL_DONE, 1'b1));
    send(fresh_event(MODE_OPEN_OK, 1'b1));
    it = fresh_event(MODE_INSERT, 1'b0);
    it.item_id = '1;
    it.item_bytes = '1;
    send(it);
    it = fresh_event(MODE_INSERT, 1'b1);
    it.item_id = '0;
    it.item_bytes = '0;
    send(it);
    send(fresh_event(MODE_WRITE_DONE, 1'b1));
    send(fresh_event(MODE_CLOSE_DONE, 1'b1));
    it = fresh_event(MODE_OPEN_OK, 1'b1);
    it.dst_addr = '1;
    it.dst_key = '1;
    it.src_addr = '1;
    it.src_key = '1;
    send(it);
    send(fresh_event(MODE_OPEN_OK, 1'b1));
    send(fresh_event(MODE_WRITE_DONE, 1'b0));
    send(fresh_event(MODE_FAIL_DONE, 1'b1));
    send(fresh_event(MODE_CLOSE_DONE, 1'b0));
    it = fresh_event(MODE_OPEN_OK, 1'b0);
    it.dst_addr = '0;
    it.dst_key = '0;
    it.src_addr = '0;
    it.src_key = '0;
    send(it);
    send(fresh_event(MODE_WRITE_DONE, 1'b1));
    send(fresh_event(MODE_FAIL_DONE, 1'b0));
    send(fresh_event(MODE_INSERT, 1'b1));
    send(fresh_event(MODE_REFUSED, 1'b1));
  endtask

  task automatic run_random(int count);
    int r;
    logic [2:0] m;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (burst == 0 && r < 12) begin
        do m = $urandom_range(0, 7); while (!is_illegal(m));
        send(fresh_event(m, $urandom));
      end else if (burst != 0 || backlog == 0 || (backlog < DEPTH && r < 40)) begin
        send(fresh_event(MODE_INSERT, $urandom));
        if (backlog < DEPTH) begin
          backlog++;
          if (backlog == 1) head_step = PH_OPEN;
        end
        if (burst != 0) burst--;
        else if ($urandom_range(0, 29) == 0) burst = $urandom_range(14, 19);
      end else begin
        case (head_step)
          PH_OPEN: begin
            r = $urandom_range(0, 9);
            if (r < 6) begin
              send(fresh_event(MODE_OPEN_OK, 1'b1));
              head_step = PH_WRITE;
            end else if (r < 8) begin
              send(fresh_event(MODE_OPEN_OK, 1'b0));
              head_step = PH_FAIL;
            end else begin
              send(fresh_event(MODE_REFUSED, $urandom));
              retire_head();
            end
          end
          PH_WRITE: begin
            send(fresh_event(MODE_WRITE_DONE, $urandom));
            head_step = PH_CLOSE;
          end
          PH_CLOSE: begin
            send(fresh_event(MODE_CLOSE_DONE, $urandom));
            retire_head();
          end
          default: begin
            send(fresh_event(MODE_FAIL_DONE, $urandom));
            retire_head();
          end
        endcase
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    configure(32'h0000_FFFF, 32'hFFFF_FFFF);
    run_directed();
    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0: configure(32'h0, 32'h0);
        2: configure(32'hFFFF_FFFF, $urandom);
        default: configure($urandom, $urandom);
      endcase
      run_random(RANDOM_EVENTS / PHASES);
    end
    settle();
    if (failures == 0 && due == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("simulation failed");
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/rsq_pkg.sv
sv/rsq_controller.sv
sv/rsq_datapath.sv
sv/rendezvous_send_queue_core.sv
test/rsq_message_checker.sv
test/tb_rendezvous_send_queue_core.sv
